@@ rtl/cll_pkg.sv @@
// cll_pkg: shared types and constants of the settings-line lexer
// no dependencies; used by cll_lexer, cll_result_fifo and config_line_lexer
`default_nettype none

package cll_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned KindW = 3;
	localparam int unsigned ErrW  = 2;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW  = 2;
	localparam int unsigned FifoCntW  = 3;

	localparam logic [KindW-1:0] KIND_IDENT  = 3'd0;
	localparam logic [KindW-1:0] KIND_INT    = 3'd1;
	localparam logic [KindW-1:0] KIND_FLOAT  = 3'd2;
	localparam logic [KindW-1:0] KIND_STRING = 3'd3;
	localparam logic [KindW-1:0] KIND_DELIM  = 3'd4;
	localparam logic [KindW-1:0] KIND_OPEN   = 3'd5;
	localparam logic [KindW-1:0] KIND_CLOSE  = 3'd6;

	localparam logic [ErrW-1:0] ERR_NONE    = 2'd0;
	localparam logic [ErrW-1:0] ERR_DOTS    = 2'd1;
	localparam logic [ErrW-1:0] ERR_UNKNOWN = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_QUOTE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ESCAPE  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DELIM   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_COMMENT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DQMODE  = 3'd4;

	localparam logic [CharW-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CharW-1:0] CH_DOT        = 8'h2E;
	localparam logic [CharW-1:0] CH_LBRACKET   = 8'h5B;
	localparam logic [CharW-1:0] CH_RBRACKET   = 8'h5D;

	typedef enum logic [6:0] {
		MODE_IDLE    = 7'b0000001,
		MODE_IDENT   = 7'b0000010,
		MODE_NUM     = 7'b0000100,
		MODE_STR     = 7'b0001000,
		MODE_ESC     = 7'b0010000,
		MODE_QQ      = 7'b0100000,
		MODE_DISCARD = 7'b1000000
	} lex_mode_t;

	typedef struct packed {
		logic [CharW-1:0] quote_char;
		logic [CharW-1:0] escape_char;
		logic [CharW-1:0] delimiter_char;
		logic [CharW-1:0] comment_char;
		logic             double_quote_mode;
	} cfg_t;

	typedef struct packed {
		logic [KindW-1:0] token_kind;
		logic [CharW-1:0] data_char;
		logic             has_char;
		logic             token_done;
		logic [ErrW-1:0]  error_code;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} lex_out_t;

endpackage

`default_nettype wire

@@ rtl/cll_lexer.sv @@
// cll_lexer: lexer state register and the per-character next-state and result logic
// depends on cll_pkg; produces zero, one or two results per accepted item
`default_nettype none

module cll_lexer (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         accept,
	input  wire  [cll_pkg::CharW-1:0]   char_code,
	input  wire                         line_end,
	input  wire  cll_pkg::cfg_t         cfg,
	output cll_pkg::lex_mode_t          mode,
	output cll_pkg::lex_out_t           lex_out
);
	import cll_pkg::*;

	typedef struct packed {
		lex_mode_t mode;
		logic      dot;
		logic      valid;
		result_t   res;
	} idle_t;

	lex_mode_t mode_q, mode_d;
	logic      dot_q, dot_d;

	function automatic logic is_letter(input logic [CharW-1:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [CharW-1:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [CharW-1:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic result_t mk(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch,
			input logic has, input logic done, input logic [ErrW-1:0] err);
		result_t r;
		r.token_kind = kind;
		r.data_char  = ch;
		r.has_char   = has;
		r.token_done = done;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic idle_t idle_byte(input logic [CharW-1:0] c, input logic dot,
			input cfg_t cf);
		idle_t o;
		o.mode  = MODE_IDLE;
		o.dot   = dot;
		o.valid = 1'b0;
		o.res   = mk(KIND_IDENT, '0, 1'b0, 1'b0, ERR_NONE);
		if (is_letter(c) || c == CH_UNDERSCORE) begin
			o.mode  = MODE_IDENT;
			o.valid = 1'b1;
			o.res   = mk(KIND_IDENT, c, 1'b1, 1'b0, ERR_NONE);
		end else if (is_digit(c) || c == CH_DOT) begin
			o.mode  = MODE_NUM;
			o.dot   = (c == CH_DOT);
			o.valid = 1'b1;
			o.res   = mk((c == CH_DOT) ? KIND_FLOAT : KIND_INT, c, 1'b1, 1'b0, ERR_NONE);
		end else if (c == cf.quote_char) begin
			o.mode = MODE_STR;
		end else if (c == cf.delimiter_char) begin
			o.valid = 1'b1;
			o.res   = mk(KIND_DELIM, '0, 1'b0, 1'b1, ERR_NONE);
		end else if (c == CH_LBRACKET) begin
			o.valid = 1'b1;
			o.res   = mk(KIND_OPEN, '0, 1'b0, 1'b1, ERR_NONE);
		end else if (c == CH_RBRACKET) begin
			o.valid = 1'b1;
			o.res   = mk(KIND_CLOSE, '0, 1'b0, 1'b1, ERR_NONE);
		end else if (c == cf.comment_char) begin
			o.mode = MODE_DISCARD;
		end else if (is_space(c)) begin
			o.mode = MODE_IDLE;
		end else begin
			o.mode  = MODE_DISCARD;
			o.valid = 1'b1;
			o.res   = mk(KIND_IDENT, '0, 1'b0, 1'b0, ERR_UNKNOWN);
		end
		return o;
	endfunction

	idle_t       idl;
	logic        pre_v, use_idle;
	result_t     pre_r;
	logic [KindW-1:0] nkind;

	always_comb begin
		nkind    = dot_q ? KIND_FLOAT : KIND_INT;
		idl      = idle_byte(char_code, dot_q, cfg);
		pre_v    = 1'b0;
		pre_r    = mk(KIND_IDENT, '0, 1'b0, 1'b0, ERR_NONE);
		use_idle = 1'b0;
		mode_d   = mode_q;
		dot_d    = dot_q;
		if (line_end) begin
			mode_d = MODE_IDLE;
			dot_d  = 1'b0;
			case (mode_q)
				MODE_IDENT: begin
					pre_v = 1'b1;
					pre_r = mk(KIND_IDENT, '0, 1'b0, 1'b1, ERR_NONE);
				end
				MODE_NUM: begin
					pre_v = 1'b1;
					pre_r = mk(nkind, '0, 1'b0, 1'b1, ERR_NONE);
				end
				MODE_STR, MODE_ESC, MODE_QQ: begin
					pre_v = 1'b1;
					pre_r = mk(KIND_STRING, '0, 1'b0, 1'b1, ERR_NONE);
				end
				default: begin
					pre_v = 1'b0;
				end
			endcase
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					pre_v = 1'b1;
					if (is_letter(char_code) || is_digit(char_code) ||
							char_code == CH_UNDERSCORE) begin
						pre_r = mk(KIND_IDENT, char_code, 1'b1, 1'b0, ERR_NONE);
					end else begin
						pre_r    = mk(KIND_IDENT, '0, 1'b0, 1'b1, ERR_NONE);
						use_idle = 1'b1;
					end
				end
				MODE_NUM: begin
					pre_v = 1'b1;
					if (is_digit(char_code)) begin
						pre_r = mk(nkind, char_code, 1'b1, 1'b0, ERR_NONE);
					end else if (char_code == CH_DOT) begin
						if (dot_q) begin
							mode_d = MODE_DISCARD;
							pre_r  = mk(KIND_IDENT, '0, 1'b0, 1'b0, ERR_DOTS);
						end else begin
							dot_d = 1'b1;
							pre_r = mk(KIND_FLOAT, char_code, 1'b1, 1'b0, ERR_NONE);
						end
					end else begin
						pre_r    = mk(nkind, '0, 1'b0, 1'b1, ERR_NONE);
						use_idle = 1'b1;
					end
				end
				MODE_STR: begin
					if (cfg.double_quote_mode) begin
						if (char_code == cfg.quote_char) begin
							mode_d = MODE_QQ;
						end else begin
							pre_v = 1'b1;
							pre_r = mk(KIND_STRING, char_code, 1'b1, 1'b0, ERR_NONE);
						end
					end else if (char_code == cfg.escape_char) begin
						mode_d = MODE_ESC;
					end else if (char_code == cfg.quote_char) begin
						mode_d = MODE_IDLE;
						pre_v  = 1'b1;
						pre_r  = mk(KIND_STRING, '0, 1'b0, 1'b1, ERR_NONE);
					end else begin
						pre_v = 1'b1;
						pre_r = mk(KIND_STRING, char_code, 1'b1, 1'b0, ERR_NONE);
					end
				end
				MODE_ESC: begin
					mode_d = MODE_STR;
					pre_v  = 1'b1;
					pre_r  = mk(KIND_STRING, char_code, 1'b1, 1'b0, ERR_NONE);
				end
				MODE_QQ: begin
					pre_v = 1'b1;
					if (char_code == cfg.quote_char) begin
						mode_d = MODE_STR;
						pre_r  = mk(KIND_STRING, char_code, 1'b1, 1'b0, ERR_NONE);
					end else begin
						pre_r    = mk(KIND_STRING, '0, 1'b0, 1'b1, ERR_NONE);
						use_idle = 1'b1;
					end
				end
				MODE_DISCARD: begin
					mode_d = MODE_DISCARD;
				end
				default: begin
					use_idle = 1'b1;
				end
			endcase
			if (use_idle) begin
				mode_d = idl.mode;
				dot_d  = idl.dot;
			end
		end
	end

	logic idle_v;

	always_comb begin
		idle_v  = use_idle && idl.valid;
		lex_out = '0;
		if (pre_v && idle_v) begin
			lex_out.count   = 2'd2;
			lex_out.r0      = pre_r;
			lex_out.r1      = idl.res;
			lex_out.r1.last = 1'b1;
		end else if (pre_v) begin
			lex_out.count   = 2'd1;
			lex_out.r0      = pre_r;
			lex_out.r0.last = 1'b1;
		end else if (idle_v) begin
			lex_out.count   = 2'd1;
			lex_out.r0      = idl.res;
			lex_out.r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			dot_q  <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			dot_q  <= dot_d;
		end
	end

	assign mode = mode_q;

endmodule

`default_nettype wire

@@ rtl/cll_result_fifo.sv @@
// cll_result_fifo: small result queue taking up to two results per transfer
// depends on cll_pkg; drives the master-side stream from its head entry
`default_nettype none

module cll_result_fifo (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           push,
	input  wire cll_pkg::lex_out_t        lex_out,
	output logic                          room,
	output logic                          out_valid,
	input  wire                           out_ready,
	output cll_pkg::result_t              out_res,
	output logic [cll_pkg::FifoCntW-1:0]  count
);
	import cll_pkg::*;

	result_t               mem_q [FifoDepth];
	logic [FifoPtrW-1:0]   wr_q, rd_q;
	logic [FifoCntW-1:0]   cnt_q;
	logic [1:0]            push_n;
	logic                  pop;

	assign push_n    = push ? lex_out.count : 2'd0;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = cnt_q <= FifoCntW'(FifoDepth - 2);
	assign out_res   = mem_q[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= lex_out.r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + FifoPtrW'(1)] <= lex_out.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FifoPtrW'(push_n);
			rd_q  <= rd_q + FifoPtrW'(pop);
			cnt_q <= cnt_q + FifoCntW'(push_n) - FifoCntW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ rtl/config_line_lexer.sv @@
// config_line_lexer: streaming tokenizer for settings-file lines, one character per transfer
// each result is registered in the result queue and presented on the master side from its head
// throughput: one input per cycle while the result queue has room; an input giving two results
// is absorbed by a four-entry result queue that holds off input when fewer than two slots are free
// reset: arst_n clears lexer state, queue and registers to their defaults
`default_nettype none

module config_line_lexer (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [7:0]                 s_tdata,   // char_code
	input  wire                        s_tlast,   // line_end
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [7:0]                 m_tdata,   // data_char
	output logic [6:0]                 m_tuser,   // token_kind, has_char, token_done, error_code
	output logic                       m_tlast,   // last
	input  wire                        cfg_we,
	input  wire  [cll_pkg::CfgIdxW-1:0] cfg_index,
	input  wire  [cll_pkg::CharW-1:0]  cfg_data
);
	import cll_pkg::*;

	cfg_t                cfg_q;
	lex_mode_t           mode;
	lex_out_t            lex_out;
	result_t             head;
	logic                accept, room;
	logic [FifoCntW-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quote_char        <= 8'd34;
			cfg_q.escape_char       <= 8'd92;
			cfg_q.delimiter_char    <= 8'd61;
			cfg_q.comment_char      <= 8'd59;
			cfg_q.double_quote_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUOTE:   cfg_q.quote_char        <= cfg_data;
				REG_ESCAPE:  cfg_q.escape_char       <= cfg_data;
				REG_DELIM:   cfg_q.delimiter_char    <= cfg_data;
				REG_COMMENT: cfg_q.comment_char      <= cfg_data;
				REG_DQMODE:  cfg_q.double_quote_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	cll_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (s_tdata),
		.line_end  (s_tlast),
		.cfg       (cfg_q),
		.mode      (mode),
		.lex_out   (lex_out)
	);

	cll_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.lex_out   (lex_out),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head),
		.count     (count)
	);

	assign m_tdata = head.data_char;
	assign m_tuser = {head.error_code, head.token_done, head.has_char, head.token_kind};
	assign m_tlast = head.last;

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= FifoCntW'(FifoDepth))
		else $error("result queue overflow");

	// line end always returns the lexer to idle
	a_line_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (mode == MODE_IDLE))
		else $error("lexer not idle after line end");

	// discarded characters give no result
	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tlast && mode == MODE_DISCARD) |-> (lex_out.count == 2'd0))
		else $error("result produced while discarding");

endmodule

`default_nettype wire
